[hdl/mrpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants for the Miller-Rabin prime test core.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int MaxBases = 12;
    localparam int WordW    = 64;

    typedef logic [WordW-1:0] word_t;

    // fixed witness bases 2..37
    function automatic logic [5:0] base_value(input logic [3:0] idx);
        logic [5:0] v;
        begin
            unique case (idx)
                4'd0:    v = 6'd2;
                4'd1:    v = 6'd3;
                4'd2:    v = 6'd5;
                4'd3:    v = 6'd7;
                4'd4:    v = 6'd11;
                4'd5:    v = 6'd13;
                4'd6:    v = 6'd17;
                4'd7:    v = 6'd19;
                4'd8:    v = 6'd23;
                4'd9:    v = 6'd29;
                4'd10:   v = 6'd31;
                4'd11:   v = 6'd37;
                default: v = 6'd37;
            endcase
            return v;
        end
    endfunction

    // request and reply between sequencer and modular multiplier
    typedef struct packed {
        logic start;
    } mm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

[hdl/mrpt_mulmod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mrpt_mulmod
    import mrpt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mm_req_t  req,
    input  word_t    a,
    input  word_t    b,
    input  word_t    m,
    output mm_stat_t stat,
    output word_t    product
);

    word_t      r_reg, r_next;
    word_t      b_reg, b_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;

    // operands below 2^63, so a doubled residue fits in 65 bits
    logic [WordW:0] dbl, dbl_red, add, add_red;

    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        add     = dbl_red + {1'b0, a};
        add_red = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
    end

    always_comb
    begin
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            r_next    = '0;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = b_reg[WordW-1] ? add_red[WordW-1:0] : dbl_red[WordW-1:0];
            b_next   = {b_reg[WordW-2:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = r_reg;

endmodule

[hdl/miller_rabin_prime_test_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_core
// Deterministic Miller-Rabin primality test of a signed 64-bit candidate.
// ----------------------------------------------------------------------------
// channel | ports                                  | direction
// in      | in_valid, in_stall, candidate[63:0]    | upstream -> core
// out     | out_valid, out_stall, prime_flag       | core -> downstream
//
// One candidate at a time; in_stall is high from the transfer until the
// result has been taken. Negative, tiny and even candidates go from the
// check state straight to the result; other odd ones first pass the mod-3
// digit fold. Each modular product runs through the bit-serial multiplier
// and a base needs at most 124 of them. rst_n clears the sequencer; out
// stalls only hold it.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_core
    import mrpt_pkg::*;
#(
    parameter int NUM_BASES = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        prime_flag
);

    localparam int NB = (NUM_BASES < MaxBases) ? NUM_BASES : MaxBases;
    localparam logic [3:0] LastBase = 4'(NB - 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_CHECK  = 10'b0000000010,
        ST_SPLIT  = 10'b0000000100,
        ST_BASE   = 10'b0000001000,
        ST_PMUL   = 10'b0000010000,
        ST_PWAIT  = 10'b0000100000,
        ST_EVAL   = 10'b0001000000,
        ST_SQWAIT = 10'b0010000000,
        ST_NEXT   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    word_t      n_reg, n_next;
    word_t      d_reg, d_next;
    logic [5:0] s_reg, s_next;
    logic [5:0] r_reg, r_next;
    logic [3:0] bidx_reg, bidx_next;
    word_t      acc_reg, acc_next;
    word_t      pb_reg, pb_next;
    word_t      e_reg, e_next;
    logic       phase_reg, phase_next;   // 0: acc*=base, 1: base*=base
    logic       res_reg, res_next;

    // mod 3 check: fold 2-bit digits one at a time (4^k = 1 mod 3)
    logic [1:0] m3_reg, m3_next;
    logic [5:0] dig_reg, dig_next;

    mm_req_t  mm_req;
    mm_stat_t mm_stat;
    word_t    mm_a, mm_b, mm_p;
    word_t    nm1;
    logic [2:0] m3_sum;

    assign nm1 = n_reg - 64'd1;

    mrpt_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .a       (mm_a),
        .b       (mm_b),
        .m       (n_reg),
        .stat    (mm_stat),
        .product (mm_p)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        bidx_next  = bidx_reg;
        acc_next   = acc_reg;
        pb_next    = pb_reg;
        e_next     = e_reg;
        phase_next = phase_reg;
        res_next   = res_reg;
        m3_next    = m3_reg;
        dig_next   = dig_reg;
        mm_req.start = 1'b0;
        mm_a = acc_reg;
        mm_b = pb_reg;
        m3_sum = {1'b0, m3_reg} + {1'b0, n_reg[{dig_reg[4:0], 1'b1}],
                                  n_reg[{dig_reg[4:0], 1'b0}]};
        if (phase_reg)
            mm_a = pb_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate;
                    m3_next    = '0;
                    dig_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (n_reg[63] || n_reg < 64'd2)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg == 64'd2 || n_reg == 64'd3)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    // one digit per cycle
                    m3_next  = (m3_sum >= 3'd3) ? 2'(m3_sum - 3'd3) : m3_sum[1:0];
                    dig_next = dig_reg + 6'd1;
                    if (dig_reg == 6'd31)
                    begin
                        if (m3_next == 2'd0)
                        begin
                            res_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            d_next     = nm1;
                            s_next     = '0;
                            state_next = ST_SPLIT;
                        end
                    end
                end
            end
            ST_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[63:1]};
                    s_next = s_reg + 6'd1;
                end
                else
                begin
                    bidx_next  = '0;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (n_reg == {58'd0, base_value(bidx_reg)})
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // small composites fall to an earlier base, so base < n here
                    acc_next   = 64'd1;
                    pb_next    = {58'd0, base_value(bidx_reg)};
                    e_next     = d_reg;
                    phase_next = 1'b0;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                if (e_reg == 64'd0)
                begin
                    r_next     = 6'd1;
                    state_next = ST_EVAL;
                end
                else if (!phase_reg && !e_reg[0])
                    phase_next = 1'b1;
                else
                begin
                    mm_req.start = 1'b1;
                    state_next   = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                if (mm_stat.done)
                begin
                    if (!phase_reg)
                    begin
                        acc_next   = mm_p;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        pb_next    = mm_p;
                        e_next     = {1'b0, e_reg[63:1]};
                        phase_next = 1'b0;
                    end
                    state_next = ST_PMUL;
                end
            end
            ST_EVAL:
            begin
                if ((r_reg == 6'd1 && acc_reg == 64'd1) || acc_reg == nm1)
                    state_next = ST_NEXT;
                else if (r_reg >= s_reg)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    // square acc; pb = acc marks the product as not yet started
                    pb_next      = acc_reg;
                    state_next   = ST_SQWAIT;
                end
            end
            ST_SQWAIT:
            begin
                mm_a = acc_reg;
                mm_b = acc_reg;
                if (!mm_stat.busy && !mm_stat.done && pb_reg == acc_reg)
                begin
                    mm_req.start = 1'b1;
                    pb_next      = ~acc_reg;
                end
                else if (mm_stat.done)
                begin
                    acc_next   = mm_p;
                    r_next     = r_reg + 6'd1;
                    state_next = ST_EVAL;
                end
            end
            ST_NEXT:
            begin
                if (bidx_reg == LastBase)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    bidx_next  = bidx_reg + 4'd1;
                    state_next = ST_BASE;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
        bidx_reg  <= bidx_next;
        acc_reg   <= acc_next;
        pb_reg    <= pb_next;
        e_reg     <= e_next;
        phase_reg <= phase_next;
        res_reg   <= res_next;
        m3_reg    <= m3_next;
        dig_reg   <= dig_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_DONE);
    assign prime_flag = res_reg;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("result shown while accepting input");

    a_mul_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        mm_stat.busy |-> (state_reg == ST_PWAIT || state_reg == ST_SQWAIT))
        else $error("multiplier busy outside a wait state");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(prime_flag)))
        else $error("stalled result changed");
`endif

endmodule

[tb/tb_miller_rabin_prime_test_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test_core
// Self-checking bench for the prime test core: drives directed and random
// candidates with bursty input timing and a stalling output, predicts each
// prime flag with a 128-bit modular arithmetic model, and checks results
// in order.
// ----------------------------------------------------------------------------
module tb_miller_rabin_prime_test_core
    import mrpt_pkg::*;
();

    localparam longint CycleLimit = 40_000_000;
    localparam int     HoldCycles = 3000;
    localparam int     NumRandom  = 80;

    class prime_scoreboard;
        bit    flags_pending[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function word_t mod_mul(word_t a, word_t b, word_t m);
            logic [127:0] prod;
            prod = a * b;
            prod = prod % {64'd0, m};
            return prod[63:0];
        endfunction

        function word_t mod_pow(word_t b, word_t e, word_t m);
            word_t acc;
            acc = 64'd1 % m;
            b   = b % m;
            while (e != 0)
            begin
                if (e[0])
                    acc = mod_mul(acc, b, m);
                b = mod_mul(b, b, m);
                e = e >> 1;
            end
            return acc;
        endfunction

        function bit expected_flag(word_t n);
            word_t d;
            word_t x;
            int    s;
            bit    ok;
            word_t bases[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
            if (n[63])
                return 0;
            if (n < 2)
                return 0;
            if (n == 2 || n == 3)
                return 1;
            if (n % 2 == 0 || n % 3 == 0)
                return 0;
            d = n - 1;
            s = 0;
            while (!d[0])
            begin
                d = d >> 1;
                s++;
            end
            for (int i = 0; i < MaxBases; i++)
            begin
                if (n == bases[i])
                    return 1;
                x = mod_pow(bases[i], d, n);
                if (x == 1 || x == n - 1)
                    continue;
                ok = 0;
                for (int r = 1; r < s; r++)
                begin
                    x = mod_mul(x, x, n);
                    if (x == n - 1)
                    begin
                        ok = 1;
                        break;
                    end
                end
                if (!ok)
                    return 0;
            end
            return 1;
        endfunction

        function void note_candidate(word_t n);
            flags_pending = {flags_pending, expected_flag(n)};
        endfunction

        function void check_flag(bit got);
            bit want;
            if (flags_pending.size() == 0)
            begin
                $error("unexpected result: prime_flag actual %0b", got);
                errors++;
                return;
            end
            want = flags_pending.pop_front();
            if (want !== got)
            begin
                $error("prime_flag mismatch: expected %0b actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [63:0] candidate = '0;
    logic        out_valid;
    logic        out_stall = 1;
    logic        prime_flag;

    prime_scoreboard sb = new();
    longint cycles = 0;
    int     burst_left = 0;

    miller_rabin_prime_test_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .candidate  (candidate),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .prime_flag (prime_flag)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // transfer one candidate; valid stays high inside a burst
    task automatic send_candidate(input word_t n);
        int gap;
        candidate <= n;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_candidate(n);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic word_t random_candidate();
        int pick;
        word_t v;
        pick = $urandom_range(0, 99);
        v = {$urandom(), $urandom()};
        if (pick < 35)
            return v;                                  // full range, mostly quick
        else if (pick < 80)
            return {48'd0, v[15:1], 1'b1};             // small odd
        else if (pick < 96)
            return {32'd0, v[31:1], 1'b1};             // medium odd
        else
            return {1'b0, v[62:1], 1'b1};              // large odd, slow
    endfunction

    // output side: long hold first so the core backs up, then a stall pattern
    initial
    begin
        int hold;
        int mode_len;
        bit busy_mode;
        hold = 0;
        mode_len = 0;
        busy_mode = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_flag(prime_flag);
            if (hold < HoldCycles)
            begin
                hold++;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_len == 0)
                begin
                    busy_mode = $urandom_range(0, 1);
                    mode_len = $urandom_range(5, 60);
                end
                mode_len--;
                out_stall <= busy_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
            end
        end
    end

    initial
    begin
        word_t directed[$] = '{
            64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF9,
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd5, 64'd25, 64'd37, 64'd41,
            64'd561, 64'd2047, 64'd3215031751, 64'd1000000007,
            64'h1FFF_FFFF_FFFF_FFFF,                 // 2^61-1, prime
            64'd9223372036854775783,                 // largest prime below 2^63
            64'h7FFF_FFFF_FFFF_FFFF,
            64'd3825123056546413051                  // strong pseudoprime to many bases
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_candidate(directed[i]);
        for (int i = 0; i < NumRandom; i++)
            send_candidate(random_candidate());
        in_valid <= 1'b0;
        while (sb.flags_pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[miller_rabin_prime_test_core.f]
hdl/mrpt_pkg.sv
hdl/mrpt_mulmod.sv
hdl/miller_rabin_prime_test_core.sv
tb/tb_miller_rabin_prime_test_core.sv
